>>> hw/rtl/pms_pkg.sv
// Shared types and constants for the periodic message scheduler.
package pms_pkg;

	localparam int RESPONSE_TYPES = 4;
	localparam int RESP_IDX_W     = (RESPONSE_TYPES > 1) ? $clog2(RESPONSE_TYPES) : 1;
	localparam int MASK_W         = 4;
	localparam int MASK_N         = (RESPONSE_TYPES < MASK_W) ? RESPONSE_TYPES : MASK_W;

	localparam int TIMER_COUNT = 7;
	localparam int PERIOD_W    = 16;
	localparam int TIME_W      = 32;
	localparam int CFG_IDX_W   = 3;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [TIMER_COUNT-1:0] timer_vec_t;

	// timer slots, also the configuration register indexes
	localparam logic [CFG_IDX_W-1:0] T_BMS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] T_DASH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] T_TORQUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] T_REQUEST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] T_FRONT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] T_FAULT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] T_SPEED   = 3'd6;

	localparam period_t PERIOD_RESET [TIMER_COUNT] = '{
		16'd1000, 16'd100, 16'd20, 16'd10, 16'd100, 16'd1000, 16'd50
	};

	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_RECORD = 1'b1;

	localparam int IN_DATA_W  = 200;
	localparam int OUT_DATA_W = 24;

	// control from the top level into the timer bank
	typedef struct packed {
		logic  go;
		logic  ready;
		time_t now;
	} pms_tick_t;

	typedef struct packed {
		logic        action;
		time_t       ms_ticks;
		logic        drive_ready;
		time_t       current_sample_ms;
		time_t       voltage_sample_ms;
		time_t       power_sample_ms;
		time_t       energy_sample_ms;
		logic [1:0]  response_index;
		time_t       response_time_ms;
	} item_t;

	typedef struct packed {
		logic              log_speed;
		logic              log_fault;
		logic [MASK_W-1:0] response_log_mask;
		logic [MASK_W-1:0] sensor_log_mask;
		logic              log_front_bus;
		logic [MASK_W-1:0] request_mask;
		logic              send_torque_command;
		logic              send_dash_heartbeat;
		logic              send_bms_heartbeat;
	} result_t;

endpackage

>>> hw/rtl/pms_timers.sv
// Bank of seven periodic timers: last-fire times, due compare and update.
module pms_timers (
	input  logic                clk,
	input  logic                arst_n,
	input  pms_pkg::period_t    periods [pms_pkg::TIMER_COUNT],
	input  pms_pkg::pms_tick_t  tick,
	output pms_pkg::timer_vec_t fire
);

	pms_pkg::time_t last_q [pms_pkg::TIMER_COUNT];
	pms_pkg::time_t due_at [pms_pkg::TIMER_COUNT];

	always_comb begin
		for (int t = 0; t < pms_pkg::TIMER_COUNT; t++) begin
			due_at[t] = last_q[t] + pms_pkg::time_t'(periods[t]);
			fire[t]   = (due_at[t] < tick.now);
		end
		// torque timer is frozen while not ready
		fire[pms_pkg::T_TORQUE] = fire[pms_pkg::T_TORQUE] & tick.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < pms_pkg::TIMER_COUNT; t++)
				last_q[t] <= '0;
		end else if (tick.go) begin
			for (int t = 0; t < pms_pkg::TIMER_COUNT; t++)
				if (fire[t])
					last_q[t] <= tick.now;
		end
	end

endmodule

>>> hw/rtl/periodic_message_scheduler.sv
// Periodic message scheduler top level: stream handshake, registers, response store.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser = action, tdata = tick/record fields
//  m_axis    out  tvalid/tready           tdata = send/log flags and masks
//  cfg       in   cfg_we (no wait)        cfg_index, cfg_data = timer period
//
// One item per cycle sustained while m_axis is ready; an item passes through the input
// register and then the output register.
// Timer and response state update when an item leaves the input register.
// A stall on m_axis holds both registers; s_axis stays ready while the input
// register is empty or moving. Reset restores default periods and clears all times.
module periodic_message_scheduler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] ms_ticks, [32] drive_ready, [64:33] current_sample_ms,
	// [96:65] voltage_sample_ms, [128:97] power_sample_ms,
	// [160:129] energy_sample_ms, [162:161] response_index,
	// [194:163] response_time_ms, [199:195] zero
	input  logic [pms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [0] action
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] send_bms_heartbeat, [1] send_dash_heartbeat, [2] send_torque_command,
	// [6:3] request_mask, [7] log_front_bus, [11:8] sensor_log_mask,
	// [15:12] response_log_mask, [16] log_fault, [17] log_speed, [23:18] zero
	output logic [pms_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  pms_pkg::period_t                   cfg_data
);

	pms_pkg::period_t   period_q [pms_pkg::TIMER_COUNT];
	pms_pkg::time_t     resp_q   [pms_pkg::RESPONSE_TYPES];
	pms_pkg::item_t     item_s1;
	logic               valid_s1;
	pms_pkg::result_t   result_s2;
	logic               valid_s2;
	logic               advance;
	pms_pkg::pms_tick_t tick;
	pms_pkg::timer_vec_t fire;
	pms_pkg::result_t   result;
	pms_pkg::item_t     item_in;
	logic [pms_pkg::RESP_IDX_W-1:0] widx;
	logic               found;

	assign item_in.action            = s_axis_tuser;
	assign item_in.ms_ticks          = s_axis_tdata[31:0];
	assign item_in.drive_ready       = s_axis_tdata[32];
	assign item_in.current_sample_ms = s_axis_tdata[64:33];
	assign item_in.voltage_sample_ms = s_axis_tdata[96:65];
	assign item_in.power_sample_ms   = s_axis_tdata[128:97];
	assign item_in.energy_sample_ms  = s_axis_tdata[160:129];
	assign item_in.response_index    = s_axis_tdata[162:161];
	assign item_in.response_time_ms  = s_axis_tdata[194:163];

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < pms_pkg::TIMER_COUNT; t++)
				period_q[t] <= pms_pkg::PERIOD_RESET[t];
		end else if (cfg_we && (32'(cfg_index) < pms_pkg::TIMER_COUNT)) begin
			period_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
	end

	assign tick.go    = advance && (item_s1.action == pms_pkg::ACT_TICK);
	assign tick.ready = item_s1.drive_ready;
	assign tick.now   = item_s1.ms_ticks;

	pms_timers u_timers (
		.clk     (clk),
		.arst_n  (arst_n),
		.periods (period_q),
		.tick    (tick),
		.fire    (fire)
	);

	assign widx = pms_pkg::RESP_IDX_W'(item_s1.response_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pms_pkg::RESPONSE_TYPES; i++)
				resp_q[i] <= '0;
		end else if (advance && (item_s1.action == pms_pkg::ACT_RECORD)
				&& (32'(item_s1.response_index) < pms_pkg::RESPONSE_TYPES)) begin
			resp_q[widx] <= item_s1.response_time_ms;
		end
	end

	always_comb begin
		result = '0;
		found  = 1'b0;
		if (item_s1.action == pms_pkg::ACT_TICK) begin
			result.send_bms_heartbeat  = fire[pms_pkg::T_BMS];
			result.send_dash_heartbeat = fire[pms_pkg::T_DASH];
			result.send_torque_command = fire[pms_pkg::T_TORQUE];
			result.log_front_bus       = fire[pms_pkg::T_FRONT];
			result.log_fault           = fire[pms_pkg::T_FAULT];
			result.log_speed           = fire[pms_pkg::T_SPEED];
			// first type whose arrival is not later than its successor
			for (int i = 0; i < pms_pkg::RESPONSE_TYPES; i++) begin
				if (!found && (resp_q[i] <= resp_q[(i + 1) % pms_pkg::RESPONSE_TYPES])) begin
					found = 1'b1;
					if (i < pms_pkg::MASK_W)
						result.request_mask[i % pms_pkg::MASK_W] = fire[pms_pkg::T_REQUEST];
				end
			end
			if (item_s1.drive_ready) begin
				result.sensor_log_mask[0] = (item_s1.current_sample_ms == item_s1.ms_ticks);
				result.sensor_log_mask[1] = (item_s1.voltage_sample_ms == item_s1.ms_ticks);
				result.sensor_log_mask[2] = (item_s1.power_sample_ms == item_s1.ms_ticks);
				result.sensor_log_mask[3] = (item_s1.energy_sample_ms == item_s1.ms_ticks);
			end
			for (int i = 0; i < pms_pkg::MASK_N; i++)
				result.response_log_mask[i] = (resp_q[i] == item_s1.ms_ticks);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_axis_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(pms_pkg::OUT_DATA_W - $bits(pms_pkg::result_t)){1'b0}}, result_s2};

	a_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.action == pms_pkg::ACT_RECORD)) |=> (result_s2 == '0))
		else $error("record transfer produced a nonzero result");

	a_req_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0(result_s2.request_mask))
		else $error("request mask is not one-hot");

	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.drive_ready) |=>
		(!result_s2.send_torque_command && (result_s2.sensor_log_mask == '0)))
		else $error("torque or sensor log raised while not ready");

endmodule
